FILE: design/tree_path_max_lca_top_defines.svh
// Assertion macros used by the tree path engine checker.
`ifndef TREE_PATH_MAX_LCA_TOP_DEFINES_SVH
`define TREE_PATH_MAX_LCA_TOP_DEFINES_SVH

// Same-cycle implication, off during reset.
`define TPM_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, off during reset.
`define TPM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// Next-cycle implication, checked through reset as well.
`define TPM_ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: design/tpm_pkg.sv
// Types, constants and helpers of the tree path engine.
`timescale 1ns / 1ps
package tpm_pkg;

   localparam int NODES       = 1024;
   localparam int LEVELS      = 10;
   localparam int WEIGHT_BITS = 32;
   localparam int NODE_BITS   = $clog2(NODES);
   localparam int LVL_BITS    = $clog2(LEVELS + 1);
   localparam int DIS_BITS    = LEVELS + 1;
   localparam int TABLE_DEPTH = NODES << LVL_BITS;
   localparam int ENTRY_BITS  = NODE_BITS + WEIGHT_BITS;

   typedef logic [NODE_BITS-1:0]   node_type;
   typedef logic [WEIGHT_BITS-1:0] weight_type;
   typedef logic [LVL_BITS-1:0]    lvl_type;
   typedef logic [DIS_BITS-1:0]    dis_type;

   typedef enum logic {
      OP_ADD   = 1'b0,
      OP_QUERY = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_UNPLACED = 2'd1,
      ST_TWICE    = 2'd2
   } status_type;

   typedef struct packed {
      op_type     op;
      node_type   node_a;
      node_type   node_b;
      weight_type weight;
   } item_type;

   typedef struct packed {
      node_type   anc;
      weight_type wmax;
   } entry_type;

   function automatic weight_type wmax(input weight_type x, input weight_type y);
      wmax = (x > y) ? x : y;
   endfunction

endpackage

FILE: design/tpm_channels.sv
// Channel interfaces of the tree path engine.
`timescale 1ns / 1ps
interface tpm_req_if;
   import tpm_pkg::*;
   logic       valid;
   logic       ready;
   logic       action;
   node_type   node_a;
   node_type   node_b;
   weight_type weight;
   modport source (output valid, action, node_a, node_b, weight, input ready);
   modport sink (input valid, action, node_a, node_b, weight, output ready);
endinterface

interface tpm_rsp_if;
   import tpm_pkg::*;
   logic       valid;
   logic       ready;
   node_type   ancestor;
   weight_type path_max;
   logic [1:0] status;
   modport source (output valid, ancestor, path_max, status, input ready);
   modport sink (input valid, ancestor, path_max, status, output ready);
endinterface

interface tpm_csr_if;
   import tpm_pkg::*;
   logic     valid;
   logic     ready;
   node_type root_node;
   modport source (output valid, root_node, input ready);
   modport sink (input valid, root_node, output ready);
endinterface

FILE: design/tpm_ram.sv
// Generic RAM: one write port, two registered read ports.
`timescale 1ns / 1ps
module tpm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr0,
   input  logic [$clog2(DEPTH)-1:0] rd_addr1,
   output logic [WIDTH-1:0]         rd_data0,
   output logic [WIDTH-1:0]         rd_data1
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data0_ff;
   logic [WIDTH-1:0] rd_data1_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data0_ff <= mem_ff[rd_addr0];
      rd_data1_ff <= mem_ff[rd_addr1];
   end

   assign rd_data0 = rd_data0_ff;
   assign rd_data1 = rd_data1_ff;

endmodule

FILE: design/tpm_front.sv
// Front end: accept and classify items into a two-entry queue.
`timescale 1ns / 1ps
module tpm_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              hold,
   tpm_req_if.sink           req_ch,
   output tpm_pkg::item_type item,
   output logic              item_valid,
   input  logic              item_pop
);
   import tpm_pkg::*;

   item_type   slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push;
   item_type   push_item;

   assign req_ch.ready = (count_ff != 2'd2) && !hold;
   assign push         = req_ch.valid && req_ch.ready;
   assign item_valid   = (count_ff != 2'd0);
   assign item         = slot_ff[rd_ptr_ff];

   always_comb begin
      push_item.op     = req_ch.action ? OP_QUERY : OP_ADD;
      push_item.node_a = req_ch.node_a;
      push_item.node_b = req_ch.node_b;
      push_item.weight = req_ch.weight;
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = item_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, item_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

FILE: design/tpm_back.sv
// Back end: tables, clearing pass, add and query sequencer, result register.
`timescale 1ns / 1ps
module tpm_back (
   input  logic              clock,
   input  logic              reset,
   input  tpm_pkg::item_type item,
   input  logic              item_valid,
   output logic              item_pop,
   output logic              clearing,
   tpm_csr_if.sink           csr_ch,
   tpm_rsp_if.source         rsp_ch
);
   import tpm_pkg::*;

   typedef enum logic [10:0] {
      S_IDLE    = 11'b00000000001,
      S_CHECK   = 11'b00000000010,
      S_ADD_RD  = 11'b00000000100,
      S_ADD_WR  = 11'b00000001000,
      S_LIFT    = 11'b00000010000,
      S_LIFT_WR = 11'b00000100000,
      S_CMP_RD  = 11'b00001000000,
      S_CMP_CHK = 11'b00010000000,
      S_FIN_RD  = 11'b00100000000,
      S_FIN_CHK = 11'b01000000000,
      S_DONE    = 11'b10000000000
   } state_type;

   state_type  state_ff, state_in;
   node_type   root_ff, root_in;
   logic       clear_ff, clear_in;
   node_type   cnt_ff, cnt_in;
   op_type     op_ff, op_in;
   node_type   a_ff, a_in;
   node_type   b_ff, b_in;
   weight_type w_ff, w_in;
   node_type   u_ff, u_in;
   node_type   v_ff, v_in;
   weight_type best_ff, best_in;
   dis_type    dis_ff, dis_in;
   lvl_type    k_ff, k_in;
   node_type   res_anc_ff, res_anc_in;
   status_type res_st_ff, res_st_in;
   logic       rsp_valid_ff, rsp_valid_in;
   node_type   rsp_anc_ff, rsp_anc_in;
   weight_type rsp_max_ff, rsp_max_in;
   status_type rsp_st_ff, rsp_st_in;

   logic       pl_we, pl_wd, pl_rd0, pl_rd1;
   node_type   pl_wa, pl_ra0, pl_ra1;
   logic       dp_we;
   node_type   dp_wd, dp_rd0, dp_rd1;
   logic       tb_we;
   entry_type  tb_wd, tb_rd0, tb_rd1, ent0, ent1;
   lvl_type    tb_wk;
   logic       load;
   logic       pa, pb;
   node_type   da, db, diff;
   weight_type nmax;

   tpm_ram #(.WIDTH(1), .DEPTH(NODES)) u_placed (
      .clock(clock), .wr_en(pl_we), .wr_addr(pl_wa), .wr_data(pl_wd),
      .rd_addr0(pl_ra0), .rd_addr1(pl_ra1), .rd_data0(pl_rd0), .rd_data1(pl_rd1)
   );

   tpm_ram #(.WIDTH(NODE_BITS), .DEPTH(NODES)) u_depth (
      .clock(clock), .wr_en(dp_we), .wr_addr(a_ff), .wr_data(dp_wd),
      .rd_addr0(pl_ra0), .rd_addr1(pl_ra1), .rd_data0(dp_rd0), .rd_data1(dp_rd1)
   );

   tpm_ram #(.WIDTH(ENTRY_BITS), .DEPTH(TABLE_DEPTH)) u_table (
      .clock(clock), .wr_en(tb_we), .wr_addr({a_ff, tb_wk}), .wr_data(tb_wd),
      .rd_addr0({u_ff, k_ff}), .rd_addr1({v_ff, k_ff}), .rd_data0(tb_rd0), .rd_data1(tb_rd1)
   );

   assign csr_ch.ready    = 1'b1;
   assign clearing        = clear_ff;
   assign rsp_ch.valid    = rsp_valid_ff;
   assign rsp_ch.ancestor = rsp_anc_ff;
   assign rsp_ch.path_max = rsp_max_ff;
   assign rsp_ch.status   = rsp_st_ff;

   always_comb begin
      item_pop = (state_ff == S_IDLE) && item_valid && !clear_ff;
      pl_ra0   = item.node_a;
      pl_ra1   = item.node_b;

      ent0 = (u_ff == root_ff) ? entry_type'{anc: root_ff, wmax: '0} : tb_rd0;
      ent1 = (v_ff == root_ff) ? entry_type'{anc: root_ff, wmax: '0} : tb_rd1;

      pa = pl_rd0 || (a_ff == root_ff);
      pb = pl_rd1 || (b_ff == root_ff);
      da = (a_ff == root_ff) ? '0 : dp_rd0;
      db = (b_ff == root_ff) ? '0 : dp_rd1;
      diff     = (da > db) ? (da - db) : (db - da);
      nmax     = wmax(best_ff, ent0.wmax);

      state_in   = state_ff;
      root_in    = root_ff;
      clear_in   = clear_ff;
      cnt_in     = cnt_ff;
      op_in      = op_ff;
      a_in       = a_ff;
      b_in       = b_ff;
      w_in       = w_ff;
      u_in       = u_ff;
      v_in       = v_ff;
      best_in    = best_ff;
      dis_in     = dis_ff;
      k_in       = k_ff;
      res_anc_in = res_anc_ff;
      res_st_in  = res_st_ff;

      pl_we = 1'b0;
      pl_wa = a_ff;
      pl_wd = 1'b1;
      dp_we = 1'b0;
      dp_wd = db + node_type'(1);
      tb_we = 1'b0;
      tb_wk = '0;
      tb_wd = '{anc: b_ff, wmax: w_ff};
      load  = 1'b0;

      if (clear_ff) begin
         pl_we  = 1'b1;
         pl_wa  = cnt_ff;
         pl_wd  = 1'b0;
         cnt_in = cnt_ff + node_type'(1);
         if (cnt_ff == node_type'(NODES - 1)) begin
            clear_in = 1'b0;
         end
      end
      if (csr_ch.valid) begin
         root_in  = csr_ch.root_node;
         clear_in = 1'b1;
         cnt_in   = '0;
      end

      case (state_ff)
         S_IDLE: begin
            if (item_pop) begin
               op_in    = item.op;
               a_in     = item.node_a;
               b_in     = item.node_b;
               w_in     = item.weight;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            best_in = '0;
            k_in    = '0;
            if (op_ff == OP_ADD) begin
               res_anc_in = a_ff;
               if (!pb) begin
                  res_st_in = ST_UNPLACED;
                  state_in  = S_DONE;
               end else if (pa) begin
                  res_st_in = ST_TWICE;
                  state_in  = S_DONE;
               end else begin
                  res_st_in = ST_OK;
                  pl_we     = 1'b1;
                  dp_we     = 1'b1;
                  tb_we     = 1'b1;
                  u_in      = b_ff;
                  best_in   = w_ff;
                  state_in  = S_ADD_RD;
               end
            end else if (!pa || !pb) begin
               res_anc_in = '0;
               res_st_in  = ST_UNPLACED;
               state_in   = S_DONE;
            end else begin
               res_st_in = ST_OK;
               u_in      = (da > db) ? b_ff : a_ff;
               v_in      = (da > db) ? a_ff : b_ff;
               dis_in    = dis_type'(diff);
               state_in  = S_LIFT;
            end
         end
         S_ADD_RD: begin
            state_in = S_ADD_WR;
         end
         S_ADD_WR: begin
            tb_we   = 1'b1;
            tb_wk   = k_ff + lvl_type'(1);
            tb_wd   = '{anc: ent0.anc, wmax: nmax};
            u_in    = ent0.anc;
            best_in = nmax;
            k_in    = k_ff + lvl_type'(1);
            if (k_ff == lvl_type'(LEVELS - 1)) begin
               state_in = S_DONE;
            end else begin
               state_in = S_ADD_RD;
            end
         end
         S_LIFT: begin
            if (dis_ff == '0) begin
               if (u_ff == v_ff) begin
                  res_anc_in = u_ff;
                  state_in   = S_DONE;
               end else begin
                  k_in     = lvl_type'(LEVELS);
                  state_in = S_CMP_RD;
               end
            end else if (dis_ff[0]) begin
               state_in = S_LIFT_WR;
            end else begin
               dis_in = dis_ff >> 1;
               k_in   = k_ff + lvl_type'(1);
            end
         end
         S_LIFT_WR: begin
            best_in  = wmax(best_ff, ent1.wmax);
            v_in     = ent1.anc;
            dis_in   = dis_ff >> 1;
            k_in     = k_ff + lvl_type'(1);
            state_in = S_LIFT;
         end
         S_CMP_RD: begin
            state_in = S_CMP_CHK;
         end
         S_CMP_CHK: begin
            if (ent0.anc != ent1.anc) begin
               best_in = wmax(best_ff, wmax(ent0.wmax, ent1.wmax));
               u_in    = ent0.anc;
               v_in    = ent1.anc;
            end
            if (k_ff == '0) begin
               state_in = S_FIN_RD;
            end else begin
               k_in     = k_ff - lvl_type'(1);
               state_in = S_CMP_RD;
            end
         end
         S_FIN_RD: begin
            state_in = S_FIN_CHK;
         end
         S_FIN_CHK: begin
            best_in    = wmax(best_ff, wmax(ent0.wmax, ent1.wmax));
            res_anc_in = ent1.anc;
            state_in   = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               load     = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      rsp_valid_in = load || (rsp_valid_ff && !rsp_ch.ready);
      rsp_anc_in   = load ? res_anc_ff : rsp_anc_ff;
      rsp_max_in   = load ? ((op_ff == OP_ADD) ? '0 : best_ff) : rsp_max_ff;
      rsp_st_in    = load ? res_st_ff : rsp_st_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         root_ff      <= '0;
         clear_ff     <= 1'b1;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         root_ff      <= root_in;
         clear_ff     <= clear_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff      <= op_in;
      a_ff       <= a_in;
      b_ff       <= b_in;
      w_ff       <= w_in;
      u_ff       <= u_in;
      v_ff       <= v_in;
      best_ff    <= best_in;
      dis_ff     <= dis_in;
      k_ff       <= k_in;
      res_anc_ff <= res_anc_in;
      res_st_ff  <= res_st_in;
      rsp_anc_ff <= rsp_anc_in;
      rsp_max_ff <= rsp_max_in;
      rsp_st_ff  <= rsp_st_in;
   end

endmodule

FILE: design/tree_path_max_lca_top.sv
// Top level of the binary-lifting tree path engine.
//
//   channel  dir  transfer carries
//   req_ch   in   action, node_a, node_b, weight
//   rsp_ch   out  ancestor, path_max, status
//   csr_ch   in   root_node
//
// An add does one table read and one table write per level.
// A query lifts the deeper node by the depth difference, bit by bit, then compares
// both nodes from the top level down, using the dual read port of the lifting table.
// After reset and after each root_node write a pass clears all NODES placed flags;
// req_ch.ready stays low through it. A stalled result waits in the output register
// while the next item is taken from the queue.
`timescale 1ns / 1ps
module tree_path_max_lca_top (
   input  logic      clock,
   input  logic      reset,
   tpm_req_if.sink   req_ch,
   tpm_rsp_if.source rsp_ch,
   tpm_csr_if.sink   csr_ch
);
   import tpm_pkg::*;

   item_type item;
   logic     item_valid;
   logic     item_pop;
   logic     clearing;

   tpm_front u_front (
      .clock(clock), .reset(reset), .hold(clearing), .req_ch(req_ch),
      .item(item), .item_valid(item_valid), .item_pop(item_pop)
   );

   tpm_back u_back (
      .clock(clock), .reset(reset), .item(item), .item_valid(item_valid),
      .item_pop(item_pop), .clearing(clearing), .csr_ch(csr_ch), .rsp_ch(rsp_ch)
   );

endmodule

FILE: design/tpm_checker.sv
// Port checker of the tree path engine and its bind.
`timescale 1ns / 1ps
`include "tree_path_max_lca_top_defines.svh"
module tpm_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_ready,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input tpm_pkg::node_type    rsp_ancestor,
   input tpm_pkg::weight_type  rsp_path_max,
   input logic [1:0]           rsp_status,
   input logic                 csr_valid,
   input logic                 csr_ready
);
   import tpm_pkg::*;

   `TPM_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_ancestor) && $stable(rsp_path_max) && $stable(rsp_status),
      "stalled result changed")
   `TPM_ASSERT_SAME(a_err_zero, clock, reset, rsp_valid && (rsp_status != ST_OK),
      rsp_path_max == '0, "error result with nonzero path_max")
   `TPM_ASSERT_NEXT(a_csr_clear, clock, reset, csr_valid && csr_ready, !req_ready,
      "item taken at start of clearing pass")
   `TPM_ASSERT_NEXT_ALWAYS(a_rst_clear, clock, reset, !req_ready,
      "item taken right after reset")

endmodule

bind tree_path_max_lca_top tpm_checker u_tpm_checker (
   .clock(clock),
   .reset(reset),
   .req_ready(req_ch.ready),
   .rsp_valid(rsp_ch.valid),
   .rsp_ready(rsp_ch.ready),
   .rsp_ancestor(rsp_ch.ancestor),
   .rsp_path_max(rsp_ch.path_max),
   .rsp_status(rsp_ch.status),
   .csr_valid(csr_ch.valid),
   .csr_ready(csr_ch.ready)
);
